// File: design/additive_wavetable_sample_generator_assert.svh
// ----------------------------------------------------------------------------
// additive wavetable sample generator assertion macros
// shared property forms for the sequencer checks
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_WAVETABLE_SAMPLE_GENERATOR_ASSERT_SVH
`define ADDITIVE_WAVETABLE_SAMPLE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define AWG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AWG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/awg_pkg.sv
// ----------------------------------------------------------------------------
// awg_pkg
// types, fixed-point constants and sequencer states of the sample generator
// ----------------------------------------------------------------------------
`default_nettype none

package awg_pkg;

    localparam int VW  = 34;
    localparam int PRW = 2 * VW;
    localparam int DVW = 10;

    typedef logic signed [VW-1:0]  val_t;
    typedef logic signed [PRW-1:0] prod_t;
    typedef logic [DVW-1:0]        dvs_t;

    localparam int FRAME_SIZE = 2048;
    localparam int MAX_FRAMES = 256;
    localparam int PH_SHIFT   = 32 - $clog2(FRAME_SIZE);

    localparam val_t ONE_Q30     = 34'sd1073741824;
    localparam val_t CORDIC_GAIN = 34'sd652032874;
    localparam val_t C_INV_PI    = 34'sd341782638;
    localparam val_t C_0P8       = 34'sd858993459;
    localparam val_t C_0P6       = 34'sd644245094;
    localparam val_t C_0P5       = 34'sd536870912;
    localparam val_t C_0P3       = 34'sd322122547;
    localparam val_t PW_SPAN     = 34'sd3435973837;
    localparam logic [31:0] PW_BASE = 32'd429496730;

    localparam logic [2:0] WT_SINE     = 3'd0;
    localparam logic [2:0] WT_SAW      = 3'd1;
    localparam logic [2:0] WT_SQUARE   = 3'd2;
    localparam logic [2:0] WT_TRIANGLE = 3'd3;
    localparam logic [2:0] WT_PWM      = 3'd4;
    localparam logic [2:0] WT_FORMANT  = 3'd5;

    localparam logic REG_WAVE_TYPE   = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_MDIV, S_PREP, S_PWMUL, S_PWSET, S_F1MUL, S_F2MUL, S_F2SET,
        S_CSTART, S_CWAIT, S_DSTART, S_DWAIT, S_PXMUL, S_PXDIV, S_PXWAIT,
        S_PYMUL, S_PYDIV, S_PYWAIT, S_PCSTART, S_PCWAIT, S_PXCMUL, S_PYSMUL,
        S_PACC, S_FMMUL, S_FMACC, S_NEXT, S_FINMUL, S_FIN
    } state_t;

    typedef struct packed {
        logic done;
        val_t sin_val;
        val_t cos_val;
    } cor_res_t;

    typedef struct packed {
        logic done;
        val_t quot;
    } div_res_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/awg_cordic.sv
// ----------------------------------------------------------------------------
// awg_cordic
// iterative rotation unit, one micro-rotation per cycle, sine and cosine
// of a 32-bit cycle fraction in Q2.30
// ----------------------------------------------------------------------------
`default_nettype none

module awg_cordic (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [31:0]      angle,
    output awg_pkg::cor_res_t     res
);
    import awg_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       flip_reg, flip_next;
    val_t       x_reg, x_next;
    val_t       y_reg, y_next;
    val_t       z_reg, z_next;

    logic        flip_in;
    logic [31:0] za;
    val_t        dx, dy, at;

    always_comb
    begin
        flip_in = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
        za      = flip_in ? (angle ^ 32'h80000000) : angle;
        dx      = y_reg >>> cnt_reg;
        dy      = x_reg >>> cnt_reg;
        at      = $signed({2'b00, atan_lut(cnt_reg)});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            flip_next = flip_in;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = $signed({{(VW-32){za[31]}}, za});
        end
        else if (busy_reg)
        begin
            if (!z_reg[VW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd29)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    always_comb
    begin
        res.done    = done_reg;
        res.sin_val = flip_reg ? -y_reg : y_reg;
        res.cos_val = flip_reg ? -x_reg : x_reg;
    end

endmodule

`default_nettype wire

// File: design/awg_div.sv
// ----------------------------------------------------------------------------
// awg_div
// restoring divider, one quotient bit per cycle, signed dividend by small
// unsigned divisor, quotient truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module awg_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire awg_pkg::val_t  dividend,
    input  wire awg_pkg::dvs_t  divisor,
    output awg_pkg::div_res_t   res
);
    import awg_pkg::*;

    localparam int CW = $clog2(VW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [VW-1:0] num_reg, num_next;
    dvs_t          rem_reg, rem_next;
    dvs_t          d_reg, d_next;

    logic [DVW:0]  sh;
    logic [DVW:0]  diff;
    logic          qbit;

    always_comb
    begin
        sh   = {rem_reg, num_reg[VW-1]};
        diff = sh - {1'b0, d_reg};
        qbit = (sh >= {1'b0, d_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[VW-1];
            num_next  = dividend[VW-1] ? 34'(-dividend) : dividend;
            rem_next  = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? diff[DVW-1:0] : sh[DVW-1:0];
            num_next = {num_reg[VW-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    always_comb
    begin
        res.done = done_reg;
        res.quot = neg_reg ? -$signed(num_reg) : $signed(num_reg);
    end

endmodule

`default_nettype wire

// File: design/additive_wavetable_sample_generator.sv
// ----------------------------------------------------------------------------
// additive_wavetable_sample_generator
// one band-limited wavetable sample per request, harmonics summed through a
// shared rotation unit, divider and multiplier under one sequencer
// ----------------------------------------------------------------------------
// One word in, one word out; the block takes no new word until the sample is
// finished. For saw, square and triangle each harmonic term costs one pass of
// the 30-step rotation unit and one pass of the 34-step divider; sine takes a
// single rotation, pwm two rotations and two divisions per harmonic, and
// formant three rotations with no division. A multi-frame table adds one
// division for the morph amount unless the frame index is at or past the last
// frame. A finished sample waits in the output register while the next word
// is already taken.
`default_nettype none

module additive_wavetable_sample_generator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         frame_index,
    input  wire logic [10:0]        sample_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [23:0]      sample_value,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [8:0]         cfg_data
);
    import awg_pkg::*;

    `include "additive_wavetable_sample_generator_assert.svh"

    state_t      state_reg, state_next;
    logic [2:0]  wave_type_reg;
    logic [8:0]  frame_count_reg;
    logic        out_valid_reg, out_valid_next;
    logic signed [23:0] sample_value_reg, sample_value_next;
    logic [31:0] ph_reg, ph_next;
    logic [16:0] m16_reg, m16_next;
    logic [31:0] pw_reg, pw_next;
    logic [31:0] a1_reg, a1_next;
    logic [31:0] a2_reg, a2_next;
    logic [31:0] ang_reg, ang_next;
    logic [31:0] pwang_reg, pwang_next;
    logic [6:0]  h_reg, h_next;
    logic        neg_reg, neg_next;
    val_t        acc_reg, acc_next;
    val_t        sin_reg, sin_next;
    val_t        cos_reg, cos_next;
    val_t        x_reg, x_next;
    val_t        y_reg, y_next;
    prod_t       p1_reg, p1_next;
    prod_t       prod_reg;

    logic        cor_start;
    logic [31:0] cor_ang;
    cor_res_t    cor_res;
    logic        div_start;
    val_t        div_num;
    dvs_t        div_den;
    div_res_t    div_res;
    val_t        mul_a, mul_b;

    logic [8:0]  n_clamp, nm1;
    logic        multi_frame, frame_sat, accept;
    logic [6:0]  h_last;
    logic        is_last, step2;
    logic [20:0] f1, f2;
    logic [9:0]  h_sq;
    val_t        mq;
    logic [PRW:0] psum;
    logic signed [PRW-31:0] fin_v;
    logic signed [PRW-30:0] fin_s;
    logic signed [PRW-38:0] fin_r;
    logic signed [23:0] fin_sat;
    logic        out_free;

    awg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (cor_ang),
        .res   (cor_res)
    );

    awg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .res      (div_res)
    );

    always_comb
    begin
        n_clamp     = (frame_count_reg > 9'(MAX_FRAMES)) ? 9'(MAX_FRAMES) : frame_count_reg;
        nm1         = n_clamp - 9'd1;
        multi_frame = n_clamp > 9'd1;
        frame_sat   = {1'b0, frame_index} >= nm1;
        accept      = in_valid && (state_reg == S_IDLE);
        case (wave_type_reg)
            WT_SAW:      h_last = 7'd64;
            WT_SQUARE:   h_last = 7'd31;
            WT_TRIANGLE: h_last = 7'd31;
            WT_PWM:      h_last = 7'd32;
            WT_FORMANT:  h_last = 7'd2;
            default:     h_last = 7'd1;
        endcase
        is_last = h_reg == h_last;
        step2   = (wave_type_reg == WT_SQUARE) || (wave_type_reg == WT_TRIANGLE);
        f1 = 21'd196608 + {2'b00, m16_reg, 2'b00} + {4'b0000, m16_reg};
        f2 = 21'd524288 + {1'b0, m16_reg, 3'b000} + {2'b00, m16_reg, 2'b00};
        h_sq = {5'b00000, h_reg[4:0]} * {5'b00000, h_reg[4:0]};
        mq   = prod_reg[VW+29:30];
        psum = {p1_reg[PRW-1], p1_reg} + {prod_reg[PRW-1], prod_reg};
        fin_v = prod_reg[PRW-1:30];
        fin_s = {fin_v[PRW-31], fin_v} + (PRW-29)'(128);
        fin_r = fin_s[PRW-30:8];
        if (fin_r > (PRW-37)'(8388607))
            fin_sat = 24'sh7FFFFF;
        else if (fin_r < -(PRW-37)'(8388608))
            fin_sat = -24'sh800000;
        else
            fin_sat = fin_r[23:0];
        out_free = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = (multi_frame && !frame_sat) ? S_MDIV : S_PREP;
            end
            S_MDIV:    if (div_res.done) state_next = S_PREP;
            S_PREP:
            begin
                if (wave_type_reg == WT_PWM)
                    state_next = S_PWMUL;
                else if (wave_type_reg == WT_FORMANT)
                    state_next = S_F1MUL;
                else
                    state_next = S_CSTART;
            end
            S_PWMUL:   state_next = S_PWSET;
            S_PWSET:   state_next = S_CSTART;
            S_F1MUL:   state_next = S_F2MUL;
            S_F2MUL:   state_next = S_F2SET;
            S_F2SET:   state_next = S_CSTART;
            S_CSTART:  state_next = S_CWAIT;
            S_CWAIT:
            begin
                if (cor_res.done)
                begin
                    if (wave_type_reg == WT_PWM)
                        state_next = S_PXMUL;
                    else if (wave_type_reg == WT_FORMANT)
                        state_next = (h_reg == 7'd0) ? S_NEXT : S_FMMUL;
                    else if (wave_type_reg == WT_SAW || step2)
                        state_next = S_DSTART;
                    else
                        state_next = S_FINMUL;
                end
            end
            S_DSTART:  state_next = S_DWAIT;
            S_DWAIT:   if (div_res.done) state_next = S_NEXT;
            S_PXMUL:   state_next = S_PXDIV;
            S_PXDIV:   state_next = S_PXWAIT;
            S_PXWAIT:  if (div_res.done) state_next = S_PYMUL;
            S_PYMUL:   state_next = S_PYDIV;
            S_PYDIV:   state_next = S_PYWAIT;
            S_PYWAIT:  if (div_res.done) state_next = S_PCSTART;
            S_PCSTART: state_next = S_PCWAIT;
            S_PCWAIT:  if (cor_res.done) state_next = S_PXCMUL;
            S_PXCMUL:  state_next = S_PYSMUL;
            S_PYSMUL:  state_next = S_PACC;
            S_PACC:    state_next = S_NEXT;
            S_FMMUL:   state_next = S_FMACC;
            S_FMACC:   state_next = S_NEXT;
            S_NEXT:    state_next = is_last ? S_FINMUL : S_CSTART;
            S_FINMUL:  state_next = S_FIN;
            S_FIN:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // unit controls
    always_comb
    begin
        in_ready  = state_reg == S_IDLE;
        cor_start = 1'b0;
        cor_ang   = ang_reg;
        div_start = 1'b0;
        div_num   = sin_reg;
        div_den   = {3'b000, h_reg};
        mul_a     = acc_reg;
        mul_b     = ONE_Q30;
        case (state_reg)
            S_IDLE:
            begin
                div_start = accept && multi_frame && !frame_sat;
                div_num   = $signed({10'd0, frame_index, 16'd0});
                div_den   = {2'b00, nm1[7:0]};
            end
            S_PWMUL:
            begin
                mul_a = PW_SPAN;
                mul_b = $signed({17'd0, m16_reg});
            end
            S_F1MUL:
            begin
                mul_a = $signed({13'd0, f1});
                mul_b = $signed({2'b00, ph_reg});
            end
            S_F2MUL:
            begin
                mul_a = $signed({13'd0, f2});
                mul_b = $signed({2'b00, ph_reg});
            end
            S_CSTART:
            begin
                cor_start = 1'b1;
                if (wave_type_reg == WT_PWM)
                    cor_ang = pwang_reg;
                else if (wave_type_reg == WT_FORMANT)
                    cor_ang = (h_reg == 7'd0) ? ph_reg : ((h_reg == 7'd1) ? a1_reg : a2_reg);
                else
                    cor_ang = ang_reg;
            end
            S_DSTART:
            begin
                div_start = 1'b1;
                div_num   = sin_reg;
                div_den   = (wave_type_reg == WT_TRIANGLE) ? h_sq : {3'b000, h_reg};
            end
            S_PXMUL:
            begin
                mul_a = sin_reg;
                mul_b = C_INV_PI;
            end
            S_PXDIV, S_PYDIV:
            begin
                div_start = 1'b1;
                div_num   = mq;
            end
            S_PYMUL:
            begin
                mul_a = ONE_Q30 - cos_reg;
                mul_b = C_INV_PI;
            end
            S_PCSTART:
            begin
                cor_start = 1'b1;
                cor_ang   = ang_reg;
            end
            S_PXCMUL:
            begin
                mul_a = x_reg;
                mul_b = cos_reg;
            end
            S_PYSMUL:
            begin
                mul_a = y_reg;
                mul_b = sin_reg;
            end
            S_FMMUL:
            begin
                mul_a = sin_reg;
                mul_b = (h_reg == 7'd1) ? C_0P5 : C_0P3;
            end
            // final scale stays on the multiplier while the result waits
            S_FINMUL, S_FIN:
            begin
                mul_a = acc_reg;
                case (wave_type_reg)
                    WT_SAW:      mul_b = C_0P5;
                    WT_SQUARE:   mul_b = C_0P6;
                    WT_TRIANGLE: mul_b = C_0P8;
                    WT_PWM:      mul_b = C_0P6;
                    WT_FORMANT:  mul_b = C_0P5;
                    default:     mul_b = ONE_Q30;
                endcase
            end
            default:
            begin
                cor_start = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        out_valid_next    = out_valid_reg && !out_ready;
        sample_value_next = sample_value_reg;
        ph_next    = ph_reg;
        m16_next   = m16_reg;
        pw_next    = pw_reg;
        a1_next    = a1_reg;
        a2_next    = a2_reg;
        ang_next   = ang_reg;
        pwang_next = pwang_reg;
        h_next     = h_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        sin_next   = sin_reg;
        cos_next   = cos_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        p1_next    = p1_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ph_next  = {sample_index, {PH_SHIFT{1'b0}}};
                    m16_next = (multi_frame && frame_sat) ? 17'h10000 : 17'd0;
                    h_next   = 7'd1;
                    neg_next = 1'b0;
                    acc_next = '0;
                end
            end
            S_MDIV:    if (div_res.done) m16_next = div_res.quot[16:0];
            S_PREP:    ang_next = ph_reg;
            S_PWSET:
            begin
                pw_next    = PW_BASE + prod_reg[47:16];
                pwang_next = PW_BASE + prod_reg[47:16];
            end
            S_F2MUL:   a1_next = prod_reg[47:16];
            S_F2SET:
            begin
                a2_next = prod_reg[47:16];
                h_next  = 7'd0;
            end
            S_CWAIT:
            begin
                if (cor_res.done)
                begin
                    sin_next = cor_res.sin_val;
                    cos_next = cor_res.cos_val;
                    if ((wave_type_reg == WT_FORMANT && h_reg == 7'd0) ||
                        (wave_type_reg != WT_PWM && wave_type_reg != WT_FORMANT &&
                         wave_type_reg != WT_SAW && !step2))
                        acc_next = cor_res.sin_val;
                end
            end
            S_DWAIT:
            begin
                if (div_res.done)
                begin
                    acc_next = neg_reg ? acc_reg - div_res.quot : acc_reg + div_res.quot;
                    neg_next = (wave_type_reg == WT_TRIANGLE) ? !neg_reg : 1'b0;
                end
            end
            S_PXWAIT:  if (div_res.done) x_next = div_res.quot;
            S_PYWAIT:  if (div_res.done) y_next = div_res.quot;
            S_PCWAIT:
            begin
                if (cor_res.done)
                begin
                    sin_next = cor_res.sin_val;
                    cos_next = cor_res.cos_val;
                end
            end
            S_PYSMUL:  p1_next = prod_reg;
            S_PACC:    acc_next = acc_reg + $signed(psum[VW+29:30]);
            S_FMACC:   acc_next = acc_reg + mq;
            S_NEXT:
            begin
                if (!is_last)
                begin
                    h_next     = step2 ? h_reg + 7'd2 : h_reg + 7'd1;
                    ang_next   = step2 ? ang_reg + {ph_reg[30:0], 1'b0} : ang_reg + ph_reg;
                    pwang_next = pwang_reg + pw_reg;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    sample_value_next = fin_sat;
                end
            end
            default:
            begin
                p1_next = p1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            wave_type_reg   <= WT_SINE;
            frame_count_reg <= 9'd1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WAVE_TYPE:   wave_type_reg   <= cfg_data[2:0];
                    REG_FRAME_COUNT: frame_count_reg <= cfg_data;
                    default:         wave_type_reg   <= wave_type_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_value_reg <= sample_value_next;
        ph_reg    <= ph_next;
        m16_reg   <= m16_next;
        pw_reg    <= pw_next;
        a1_reg    <= a1_next;
        a2_reg    <= a2_next;
        ang_reg   <= ang_next;
        pwang_reg <= pwang_next;
        h_reg     <= h_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        sin_reg   <= sin_next;
        cos_reg   <= cos_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        p1_reg    <= p1_next;
        prod_reg  <= mul_a * mul_b;
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_value_reg;

    `AWG_ASSERT_NXT(a_busy_after_word, in_valid && in_ready, !in_ready,
        "sequencer still ready after taking a word")
    `AWG_ASSERT_IMP(a_cordic_done_waited, cor_res.done,
        state_reg == S_CWAIT || state_reg == S_PCWAIT,
        "rotation result arrived with no one waiting")
    `AWG_ASSERT_IMP(a_div_done_waited, div_res.done,
        state_reg == S_MDIV || state_reg == S_DWAIT || state_reg == S_PXWAIT ||
        state_reg == S_PYWAIT,
        "quotient arrived with no one waiting")
    `AWG_ASSERT_IMP(a_harmonic_bound, state_reg == S_NEXT, h_reg <= h_last,
        "harmonic counter ran past its last term")

endmodule

`default_nettype wire

// File: dv/additive_wavetable_sample_generator_chk.sv
// ----------------------------------------------------------------------------
// additive wavetable sample generator checker
// watches the request, result and register ports, computes each expected
// sample in fixed point from the live register copy and compares in order
// ----------------------------------------------------------------------------
`default_nettype none

module additive_wavetable_sample_generator_chk (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [7:0]         frame_index,
    input  wire logic [10:0]        sample_index,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [23:0] sample_value,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [8:0]         cfg_data,
    output int                      errors,
    output int                      pending
);
    import awg_pkg::*;

    localparam longint Q30_ONE  = 64'sd1073741824;
    localparam longint ROT_GAIN = 64'sd652032874;
    localparam longint INV_PI   = 64'sd341782638;
    localparam longint K_0P8    = 64'sd858993459;
    localparam longint K_0P6    = 64'sd644245094;
    localparam longint K_0P5    = 64'sd536870912;
    localparam longint K_0P3    = 64'sd322122547;
    localparam longint unsigned PWM_BASE = 64'd429496730;
    localparam longint unsigned PWM_SPAN = 64'd3435973837;

    localparam logic [31:0] ROT_ANGLE [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    logic [2:0]         wave_q;
    logic [8:0]         frames_q;
    logic signed [23:0] sample_queue [$];

    function automatic longint fmul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // sine and cosine of a cycle fraction, Q2.30
    function automatic void rotate(input logic [31:0] ang, output longint s,
                                   output longint c);
        logic        flip;
        logic [31:0] za;
        longint      x, y, z, dx, dy;
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        za   = flip ? ang - 32'h80000000 : ang;
        z    = longint'($signed(za));
        x    = ROT_GAIN;
        y    = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(ROT_ANGLE[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(ROT_ANGLE[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint sine(input logic [31:0] ang);
        longint s, c;
        rotate(ang, s, c);
        return s;
    endfunction

    function automatic logic signed [23:0] synth_sample(input logic [2:0] wave,
            input logic [8:0] frames, input logic [7:0] fr, input logic [10:0] idx);
        longint unsigned ph64, m16, n, f1, f2;
        logic [31:0]     ph, pw, a1, a2;
        longint          acc, s, c, s2, c2, x, y, t, r;
        ph64 = longint'(idx) << 21;
        ph   = ph64[31:0];
        n    = (frames > 9'(MAX_FRAMES)) ? MAX_FRAMES : frames;
        m16  = 0;
        acc  = 0;
        if (n > 1)
            m16 = (fr >= n - 1) ? 65536 : (longint'(fr) << 16) / (n - 1);
        case (wave)
            WT_SAW:
            begin
                for (int h = 1; h <= 64; h++)
                    acc += sine(32'(h) * ph) / h;
                acc = fmul(acc, K_0P5);
            end
            WT_SQUARE:
            begin
                for (int h = 1; h <= 31; h += 2)
                    acc += sine(32'(h) * ph) / h;
                acc = fmul(acc, K_0P6);
            end
            WT_TRIANGLE:
            begin
                for (int h = 1; h <= 31; h += 2)
                begin
                    t = sine(32'(h) * ph) / (h * h);
                    acc += (((h - 1) / 2) % 2 == 1) ? -t : t;
                end
                acc = fmul(acc, K_0P8);
            end
            WT_PWM:
            begin
                pw = 32'(PWM_BASE + ((PWM_SPAN * m16) >> 16));
                for (int h = 1; h <= 32; h++)
                begin
                    rotate(32'(h) * pw, s2, c2);
                    x = fmul(s2, INV_PI) / h;
                    y = fmul(Q30_ONE - c2, INV_PI) / h;
                    rotate(32'(h) * ph, s, c);
                    acc += (x * c + y * s) >>> 30;
                end
                acc = fmul(acc, K_0P6);
            end
            WT_FORMANT:
            begin
                f1  = (64'd3 << 16) + 5 * m16;
                f2  = (64'd8 << 16) + 12 * m16;
                a1  = 32'((f1 * ph64) >> 16);
                a2  = 32'((f2 * ph64) >> 16);
                acc = sine(ph) + fmul(sine(a1), K_0P5) + fmul(sine(a2), K_0P3);
                acc = fmul(acc, K_0P5);
            end
            default: acc = sine(ph);
        endcase
        r = (acc + 128) >>> 8;
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[23:0];
    endfunction

    assign pending = sample_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [23:0] want;
        if (!rst_n)
        begin
            wave_q   <= WT_SINE;
            frames_q <= 9'd1;
            errors   <= 0;
            sample_queue.delete();
        end
        else
        begin
            if (cfg_we && cfg_index == REG_WAVE_TYPE)
                wave_q <= cfg_data[2:0];
            if (cfg_we && cfg_index == REG_FRAME_COUNT)
                frames_q <= cfg_data;
            if (in_valid && in_ready)
                sample_queue.push_back(synth_sample(wave_q, frames_q, frame_index,
                                                    sample_index));
            if (out_valid && out_ready)
            begin
                if (sample_queue.size() == 0)
                begin
                    $error("sample_value: unexpected word %0d", sample_value);
                    errors <= errors + 1;
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (sample_value !== want)
                    begin
                        $error("sample_value: expected %0d, actual %0d", want,
                               sample_value);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: dv/additive_wavetable_sample_generator_tb.sv
// ----------------------------------------------------------------------------
// additive wavetable sample generator testbench
// directed corner requests for every wave code, then random requests over
// random register settings and handshake idling; a side checker predicts
// ----------------------------------------------------------------------------
`default_nettype none

module additive_wavetable_sample_generator_tb;
    import awg_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         frame_index = '0;
    logic [10:0]        sample_index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [23:0] sample_value;
    logic               cfg_we = 1'b0;
    logic               cfg_index = REG_WAVE_TYPE;
    logic [8:0]         cfg_data = '0;
    int                 errors, pending;
    int                 send_idle = 0, recv_stall = 0, hold_off = 0;
    int                 quiet = 0, sent = 0, settings = 0;

    always #1 clk = ~clk;

    additive_wavetable_sample_generator dut (.*);

    additive_wavetable_sample_generator_chk chk (.*);

    // receiver side, long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] fr, input logic [10:0] idx);
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid     <= 1'b1;
        frame_index  <= fr;
        sample_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_regs(input logic [2:0] wave, input logic [8:0] frames);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_WAVE_TYPE;
        cfg_data  <= 9'(wave);
        @(posedge clk);
        cfg_index <= REG_FRAME_COUNT;
        cfg_data  <= frames;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    function automatic logic [10:0] pick_index();
        case ($urandom_range(9))
            0:       return 11'd0;
            1:       return 11'd2047;
            default: return 11'($urandom_range(2047));
        endcase
    endfunction

    initial
    begin
        logic [2:0] wave;
        logic [8:0] frames;
        int         count, phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every wave code at the field extremes and midpoints
        for (int w = 0; w < 8; w++)
        begin
            set_regs(3'(w), 9'd256);
            send_word(8'd0, 11'd0);
            send_word(8'd255, 11'd2047);
            send_word(8'd128, 11'd1024);
        end
        set_regs(WT_FORMANT, 9'd0);
        send_word(8'd200, 11'd300);
        set_regs(WT_FORMANT, 9'd511);
        send_word(8'd255, 11'd2000);

        // fill the block with the receiver held off
        set_regs(WT_SINE, 9'd1);
        hold_off <= 400;
        repeat (30) send_word(8'($urandom_range(255)), pick_index());

        phase = 0;
        while (sent < 1150)
        begin
            wave = 3'($urandom_range(7));
            case ($urandom_range(7))
                0:       frames = 9'd0;
                1:       frames = 9'd1;
                2:       frames = 9'd2;
                3:       frames = 9'd256;
                4:       frames = 9'($urandom_range(511, 257));
                default: frames = 9'($urandom_range(255, 2));
            endcase
            set_regs(wave, frames);
            case (phase % 5)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 46; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 46; end
                3: begin send_idle = 28; recv_stall = 28; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            phase++;
            case (wave)
                WT_SAW:                   count = 6;
                WT_PWM:                   count = 5;
                WT_SQUARE, WT_TRIANGLE:   count = 20;
                default:                  count = 90;
            endcase
            repeat (count)
                send_word(8'($urandom_range(255)), pick_index());
        end
        drain();
        repeat (100) @(posedge clk);

        $display("covered %0d requests over %0d register settings, all wave codes",
                 sent, settings);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
